>>> src/packed_2bpp_row_blitter_assert.svh
// assertion macros for the packed 2bpp row blitter
`ifndef PACKED_2BPP_ROW_BLITTER_ASSERT_SVH
`define PACKED_2BPP_ROW_BLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define P2RB_ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define P2RB_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define P2RB_ASSERT_IMPL(lbl, clk, rstn, a, b)
`define P2RB_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

>>> src/p2rb_pkg.sv
// types, codes and pixel helpers shared by the row blitter modules
`timescale 1ns / 1ps
`default_nettype none
package p2rb_pkg;

    typedef enum logic [2:0] {
        CMD_SET     = 3'd0,
        CMD_GET     = 3'd1,
        CMD_FILL    = 3'd2,
        CMD_INVERT  = 3'd3,
        CMD_COPY    = 3'd4,
        CMD_SWAP    = 3'd5,
        CMD_HSCROLL = 3'd6,
        CMD_NONE    = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_START,
        ST_RD_SRC,
        ST_CAP_A,
        ST_RD_B,
        ST_CAP_B,
        ST_RD_DST,
        ST_WR_DST,
        ST_RD_DST2,
        ST_WR_DST2,
        ST_ADV,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup1;
        logic setup2;
        logic start_fill;
        logic rd_src;
        logic cap_a;
        logic rd_b;
        logic cap_b;
        logic rd_dst;
        logic wr_dst;
        logic rd_dst2;
        logic wr_dst2;
        logic adv;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic act;
        logic is_get;
        logic use_src;
        logic is_swap;
        logic move_zero;
        logic fill_zero;
        logic last;
        logic fill_phase;
        logic out_free;
    } ctrl_stat_t;

    // pixel of a byte, leftmost in bits 7:6
    function automatic logic [1:0] get_px(input logic [7:0] b, input logic [1:0] lane);
        logic [1:0] r;
        case (lane)
            2'd0:    r = b[7:6];
            2'd1:    r = b[5:4];
            2'd2:    r = b[3:2];
            default: r = b[1:0];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] put_px(input logic [7:0] b, input logic [1:0] lane,
                                          input logic [1:0] v);
        logic [7:0] r;
        r = b;
        case (lane)
            2'd0:    r[7:6] = v;
            2'd1:    r[5:4] = v;
            2'd2:    r[3:2] = v;
            default: r[1:0] = v;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/p2rb_ctrl.sv
// sequencer for the row blitter: steps each pixel through read, modify and write
`timescale 1ns / 1ps
`default_nettype none
module p2rb_ctrl
    import p2rb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP1;
                end
            end
            ST_SETUP1: begin
                cmd.setup1 = 1'b1;
                state_next = ST_SETUP2;
            end
            ST_SETUP2: begin
                cmd.setup2 = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                if (!stat.act) begin
                    state_next = ST_DONE;
                end else if (stat.is_get) begin
                    state_next = ST_RD_SRC;
                end else if (!stat.move_zero) begin
                    state_next = stat.use_src ? ST_RD_SRC : ST_RD_DST;
                end else if (!stat.fill_zero) begin
                    cmd.start_fill = 1'b1;
                    state_next     = ST_RD_DST;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_SRC: begin
                cmd.rd_src = 1'b1;
                state_next = ST_CAP_A;
            end
            ST_CAP_A: begin
                cmd.cap_a = 1'b1;
                if (stat.is_get) begin
                    state_next = ST_DONE;
                end else if (stat.is_swap) begin
                    state_next = ST_RD_B;
                end else begin
                    state_next = ST_RD_DST;
                end
            end
            ST_RD_B: begin
                cmd.rd_b   = 1'b1;
                state_next = ST_CAP_B;
            end
            ST_CAP_B: begin
                cmd.cap_b  = 1'b1;
                state_next = ST_RD_DST;
            end
            ST_RD_DST: begin
                cmd.rd_dst = 1'b1;
                state_next = ST_WR_DST;
            end
            ST_WR_DST: begin
                cmd.wr_dst = 1'b1;
                state_next = (stat.is_swap && !stat.fill_phase) ? ST_RD_DST2 : ST_ADV;
            end
            ST_RD_DST2: begin
                cmd.rd_dst2 = 1'b1;
                state_next  = ST_WR_DST2;
            end
            ST_WR_DST2: begin
                cmd.wr_dst2 = 1'b1;
                state_next  = ST_ADV;
            end
            ST_ADV: begin
                if (stat.last) begin
                    if (!stat.fill_phase && !stat.fill_zero) begin
                        cmd.start_fill = 1'b1;
                        state_next     = ST_RD_DST;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    cmd.adv    = 1'b1;
                    state_next = stat.use_src ? ST_RD_SRC : ST_RD_DST;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/p2rb_dpath.sv
// datapath for the row blitter: command registers, span set-up, frame store, output word
`timescale 1ns / 1ps
`default_nettype none
module p2rb_dpath
    import p2rb_pkg::*;
#(
    parameter int WIDTH  = 640,
    parameter int HEIGHT = 480
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ctrl_cmd_t          cmd,
    output ctrl_stat_t              stat,
    input  wire logic        [2:0]  s_cmd,
    input  wire logic        [8:0]  s_row_a,
    input  wire logic        [8:0]  s_row_b,
    input  wire logic        [9:0]  s_x_first,
    input  wire logic        [9:0]  s_x_last,
    input  wire logic        [1:0]  s_color_index,
    input  wire logic signed [10:0] s_shift,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic             [1:0]  m_read_pixel,
    output logic                    m_empty_span
);

    localparam int ROW_BYTES = (WIDTH + 3) / 4;
    localparam int DEPTH     = ROW_BYTES * HEIGHT;
    localparam int AW        = $clog2(DEPTH);
    localparam logic [10:0] W_LIM = 11'(WIDTH);
    localparam logic [10:0] H_LIM = 11'(HEIGHT);
    localparam logic [9:0]  X_MAX = 10'(WIDTH - 1);

    // captured word
    cmd_t        cmd_reg;
    logic [8:0]  ra_reg, rb_reg;
    logic [9:0]  xf_reg, xl_reg;
    logic [1:0]  c_reg;
    logic [10:0] s_reg;

    // span set-up
    logic          empty_reg, act_reg, neg_reg;
    logic [9:0]    xlc_reg;
    logic [10:0]   w_reg, m_reg;
    logic [AW-1:0] base_a_reg, base_b_reg;
    logic [10:0]   fill_n_reg, cnt_reg, off_reg;
    logic [9:0]    fill_start_reg, dst_reg;
    logic          down_reg, fill_phase_reg;

    // pixel work
    logic [1:0]    pa_reg, pb_reg;
    logic [7:0]    rdata_reg;
    logic [AW-1:0] waddr_reg;
    logic [7:0]    mem [DEPTH];

    logic          out_valid_reg;
    logic [1:0]    out_px_reg;
    logic          out_empty_reg;

    logic          span_c, empty_c, act_c, big_c, mv_c;
    logic [10:0]   xf_w, xl_w, xlc_w, m_c, sx_w;
    logic [9:0]    sx;
    logic [AW-1:0] src_base, raddr;
    logic          we;
    logic [7:0]    wdata;
    logic [1:0]    wval;

    // command capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= cmd_t'(s_cmd);
            ra_reg  <= s_row_a;
            rb_reg  <= s_row_b;
            xf_reg  <= s_x_first;
            xl_reg  <= s_x_last;
            c_reg   <= s_color_index;
            s_reg   <= s_shift;
        end
    end

    // first set-up step: flags, clipped end, width, shift magnitude, row bases
    always_comb begin
        xf_w    = {1'b0, xf_reg};
        xl_w    = {1'b0, xl_reg};
        xlc_w   = (xl_w >= W_LIM) ? {1'b0, X_MAX} : xl_w;
        m_c     = s_reg[10] ? (11'd0 - s_reg) : s_reg;
        span_c  = (cmd_reg == CMD_FILL) || (cmd_reg == CMD_INVERT) || (cmd_reg == CMD_COPY)
               || (cmd_reg == CMD_SWAP) || (cmd_reg == CMD_HSCROLL);
        empty_c = span_c && (xl_reg < xf_reg);
        act_c   = 1'b0;
        case (cmd_reg)
            CMD_SET, CMD_GET: act_c = ({2'b0, ra_reg} < H_LIM) && (xf_w < W_LIM);
            CMD_FILL, CMD_INVERT: act_c = !empty_c && (xf_w < W_LIM) && ({2'b0, ra_reg} < H_LIM);
            CMD_COPY, CMD_SWAP: act_c = !empty_c && (xf_w < W_LIM) && ({2'b0, ra_reg} < H_LIM)
                                     && ({2'b0, rb_reg} < H_LIM);
            CMD_HSCROLL: act_c = !empty_c && (xf_w < W_LIM) && ({2'b0, ra_reg} < H_LIM)
                              && (s_reg != 11'd0);
            default: act_c = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup1) begin
            empty_reg  <= empty_c;
            act_reg    <= act_c;
            neg_reg    <= s_reg[10];
            xlc_reg    <= xlc_w[9:0];
            w_reg      <= xlc_w - xf_w + 11'd1;
            m_reg      <= m_c;
            base_a_reg <= AW'(ra_reg * ROW_BYTES);
            base_b_reg <= AW'(rb_reg * ROW_BYTES);
        end
    end

    // second set-up step: move and fill runs
    assign big_c = (m_reg >= w_reg);
    assign mv_c  = (cmd_reg == CMD_HSCROLL) && !big_c;

    always_ff @(posedge aclk) begin
        if (cmd.setup2) begin
            case (cmd_reg)
                CMD_INVERT, CMD_COPY, CMD_SWAP: cnt_reg <= w_reg;
                CMD_HSCROLL: cnt_reg <= big_c ? 11'd0 : (w_reg - m_reg);
                default: cnt_reg <= 11'd0;
            endcase
            case (cmd_reg)
                CMD_SET: fill_n_reg <= 11'd1;
                CMD_FILL: fill_n_reg <= w_reg;
                CMD_HSCROLL: fill_n_reg <= big_c ? w_reg : m_reg;
                default: fill_n_reg <= 11'd0;
            endcase
            fill_start_reg <= (mv_c && neg_reg)
                            ? 10'({1'b0, xlc_reg} - m_reg + 11'd1) : xf_reg;
            dst_reg        <= (mv_c && !neg_reg) ? xlc_reg : xf_reg;
            down_reg       <= mv_c && !neg_reg;
            off_reg        <= (cmd_reg == CMD_HSCROLL) ? m_reg : 11'd0;
            fill_phase_reg <= 1'b0;
        end else if (cmd.start_fill) begin
            cnt_reg        <= fill_n_reg;
            dst_reg        <= fill_start_reg;
            down_reg       <= 1'b0;
            fill_phase_reg <= 1'b1;
        end else if (cmd.adv) begin
            cnt_reg <= cnt_reg - 11'd1;
            dst_reg <= down_reg ? (dst_reg - 10'd1) : (dst_reg + 10'd1);
        end
    end

    // source column and read address
    assign sx_w     = down_reg ? ({1'b0, dst_reg} - off_reg) : ({1'b0, dst_reg} + off_reg);
    assign sx       = sx_w[9:0];
    assign src_base = (cmd_reg == CMD_COPY) ? base_b_reg : base_a_reg;

    always_comb begin
        raddr = '0;
        if (cmd.rd_src) begin
            raddr = src_base + AW'(sx[9:2]);
        end else if (cmd.rd_b || cmd.rd_dst2) begin
            raddr = base_b_reg + AW'(dst_reg[9:2]);
        end else if (cmd.rd_dst) begin
            raddr = base_a_reg + AW'(dst_reg[9:2]);
        end
    end

    // write value
    always_comb begin
        if (cmd.wr_dst2) begin
            wval = pa_reg;
        end else if (fill_phase_reg) begin
            wval = c_reg;
        end else begin
            case (cmd_reg)
                CMD_INVERT: wval = pa_reg ^ 2'b11;
                CMD_SWAP:   wval = pb_reg;
                default:    wval = pa_reg;
            endcase
        end
    end

    assign we    = cmd.wr_dst || cmd.wr_dst2;
    assign wdata = put_px(rdata_reg, dst_reg[1:0], wval);

    // frame store
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr_reg] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // pixel capture and write address hold
    always_ff @(posedge aclk) begin
        if (cmd.rd_dst || cmd.rd_dst2) begin
            waddr_reg <= raddr;
        end
        if (cmd.cap_a) begin
            pa_reg <= get_px(rdata_reg, sx[1:0]);
        end
        if (cmd.cap_b) begin
            pb_reg <= get_px(rdata_reg, dst_reg[1:0]);
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_px_reg    <= ((cmd_reg == CMD_GET) && act_reg) ? pa_reg : 2'd0;
            out_empty_reg <= empty_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_pixel = out_px_reg;
    assign m_empty_span = out_empty_reg;

    // status
    always_comb begin
        stat.act        = act_reg;
        stat.is_get     = (cmd_reg == CMD_GET);
        stat.use_src    = !fill_phase_reg && ((cmd_reg == CMD_INVERT) || (cmd_reg == CMD_COPY)
                       || (cmd_reg == CMD_SWAP) || (cmd_reg == CMD_HSCROLL));
        stat.is_swap    = (cmd_reg == CMD_SWAP);
        stat.move_zero  = (cnt_reg == 11'd0);
        stat.fill_zero  = (fill_n_reg == 11'd0);
        stat.last       = (cnt_reg == 11'd1);
        stat.fill_phase = fill_phase_reg;
        stat.out_free   = !out_valid_reg || m_ready;
    end

endmodule
`default_nettype wire

>>> src/packed_2bpp_row_blitter.sv
// top level of the packed 2bpp row blitter
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    cmd, row_a, row_b, x_first, x_last, color_index, shift
// m_       out  m_valid/m_ready    read_pixel, empty_span
//
// one command at a time: accept, set-up steps setup1, setup2 and start, the pixel steps,
// then the done state that loads the result. per pixel, set and fill read and write the
// destination; invert, copy and scroll moves first read and capture the source pixel;
// swap also reads and writes the second row. the frame store's registered read data sets
// the per-pixel cost. reset is synchronous active low; the frame store is not cleared.
// a waiting result does not stop the next command being taken; a new result waits
// in the done state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_2bpp_row_blitter_assert.svh"
module packed_2bpp_row_blitter
    import p2rb_pkg::*;
#(
    parameter int WIDTH  = 640,
    parameter int HEIGHT = 480
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [2:0]  s_cmd,
    input  wire logic        [8:0]  s_row_a,
    input  wire logic        [8:0]  s_row_b,
    input  wire logic        [9:0]  s_x_first,
    input  wire logic        [9:0]  s_x_last,
    input  wire logic        [1:0]  s_color_index,
    input  wire logic signed [10:0] s_shift,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic             [1:0]  m_read_pixel,
    output logic                    m_empty_span
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencer
    p2rb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath and frame store
    p2rb_dpath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_cmd         (s_cmd),
        .s_row_a       (s_row_a),
        .s_row_b       (s_row_b),
        .s_x_first     (s_x_first),
        .s_x_last      (s_x_last),
        .s_color_index (s_color_index),
        .s_shift       (s_shift),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_pixel  (m_read_pixel),
        .m_empty_span  (m_empty_span)
    );

    // a taken word starts set-up and the block goes busy
    `P2RB_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready && cmd.setup1)
    // the store is never written while idle
    `P2RB_ASSERT_IMPL(a_no_write_idle, aclk, aresetn, cmd.wr_dst || cmd.wr_dst2, !s_ready)
    // a read pixel and an empty flag never come together
    `P2RB_ASSERT_IMPL(a_px_or_empty, aclk, aresetn, m_valid && (m_read_pixel != 2'd0),
                      !m_empty_span)
    // a result loads only into a free output register
    `P2RB_ASSERT_IMPL(a_out_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready)

endmodule
`default_nettype wire
